// ===== rtl/pord_pkg.sv =====
// shared types and constants for the permutation order block
`timescale 1ns / 1ps
package pord_pkg;

  localparam int unsigned IMAGE_W  = 14;
  localparam int unsigned COUNT_W  = 14;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned ORDER_W  = 48;
  localparam int unsigned HALF_W   = 24;

  localparam logic [ORDER_W-1:0] ORDER_MAX = {ORDER_W{1'b1}};

  localparam logic [STATUS_W-1:0] STATUS_OK  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_SAT = 2'd2;

  typedef struct packed {
    logic invalid;
  } pord_job_t;

  typedef struct packed {
    logic idle;
    logic queue_empty;
  } pord_stat_t;

endpackage

// ===== rtl/pord_ram.sv =====
// generic single write, single registered read memory
`timescale 1ns / 1ps
module pord_ram #(
  parameter int unsigned WIDTH = 13,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/pord_div.sv =====
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module pord_div #(
  parameter int unsigned DW = 48,
  parameter int unsigned VW = 14
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] a_i,
  input  logic [VW-1:0] b_i,
  output logic          done_o,
  output logic [DW-1:0] quo_o,
  output logic [VW-1:0] rem_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic [DW-1:0] quo_q;
  logic [VW-1:0] rem_q;
  logic [VW-1:0] div_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;
  logic [VW:0]   trial;
  logic          ge;

  assign trial = {rem_q, quo_q[DW-1]};
  assign ge    = trial >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= a_i;
      rem_q <= '0;
      div_q <= b_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DW-2:0], ge};
      rem_q <= ge ? VW'(trial - {1'b0, div_q}) : trial[VW-1:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/pord_fifo.sv =====
// two entry job queue between loader and walker
`timescale 1ns / 1ps
module pord_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pord_pkg::pord_job_t push_data_i,
  input  logic              pop_i,
  output pord_pkg::pord_job_t pop_data_o,
  output logic              empty_o,
  output logic              full_o
);
  import pord_pkg::*;

  pord_job_t   mem_q [2];
  logic        wr_q;
  logic        rd_q;
  logic [1:0]  cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i && !full_o) begin
        wr_q <= ~wr_q;
      end
      if (pop_i && !empty_o) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i && !full_o} - {1'b0, pop_i && !empty_o};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  assign pop_data_o = mem_q[rd_q];
  assign empty_o    = (cnt_q == 2'd0);
  assign full_o     = (cnt_q == 2'd2);

endmodule

// ===== rtl/pord_front.sv =====
// loader: takes images, checks them and fills the store
`timescale 1ns / 1ps
module pord_front #(
  parameter int unsigned LW = 14,
  parameter int unsigned AW = 13
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         restart_i,
  input  logic [LW-1:0]                n_i,
  input  pord_pkg::pord_stat_t         stat_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [pord_pkg::IMAGE_W-1:0] image_i,
  output logic [AW-1:0]                seen_raddr_o,
  input  logic                         seen_rdata_i,
  output logic                         seen_we_o,
  output logic [AW-1:0]                seen_waddr_o,
  output logic                         img_we_o,
  output logic [AW-1:0]                img_waddr_o,
  output logic [AW-1:0]                img_wdata_o,
  output logic                         push_o,
  output pord_pkg::pord_job_t          push_data_o
);
  import pord_pkg::*;

  typedef enum logic {F_IDLE, F_CHK} fstate_e;

  fstate_e            state_q;
  logic [LW-1:0]      load_q;
  logic               invalid_q;
  logic               range_q;
  logic [IMAGE_W-1:0] img_q;
  logic [IMAGE_W-1:0] img_m1;
  logic [IMAGE_W-1:0] stored_m1;
  logic               bad;
  logic               last;

  assign img_m1      = image_i - IMAGE_W'(1);
  assign stored_m1   = img_q - IMAGE_W'(1);
  assign in_ready_o  = (state_q == F_IDLE) && stat_i.idle && stat_i.queue_empty;
  assign seen_raddr_o = AW'(img_m1);
  assign bad         = !range_q || seen_rdata_i;
  assign last        = (load_q + LW'(1)) == n_i;

  assign img_we_o     = (state_q == F_CHK);
  assign img_waddr_o  = AW'(load_q);
  assign img_wdata_o  = bad ? '0 : AW'(stored_m1);
  assign seen_we_o    = (state_q == F_CHK) && !bad;
  assign seen_waddr_o = AW'(stored_m1);
  assign push_o       = (state_q == F_CHK) && last;
  assign push_data_o.invalid = invalid_q || bad;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= F_IDLE;
      load_q    <= '0;
      invalid_q <= 1'b0;
      range_q   <= 1'b0;
      img_q     <= '0;
    end else if (restart_i) begin
      state_q   <= F_IDLE;
      load_q    <= '0;
      invalid_q <= 1'b0;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (in_valid_i && in_ready_o) begin
            img_q   <= image_i;
            range_q <= (image_i != '0) && (32'(image_i) <= 32'(n_i));
            state_q <= F_CHK;
          end
        end
        F_CHK: begin
          state_q <= F_IDLE;
          if (last) begin
            load_q    <= '0;
            invalid_q <= 1'b0;
          end else begin
            load_q    <= load_q + LW'(1);
            invalid_q <= invalid_q || bad;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/pord_back.sv =====
// walker: clears marks, follows cycles, folds lcm and holds the result
`timescale 1ns / 1ps
module pord_back #(
  parameter int unsigned MAX_POINTS = 8192,
  parameter int unsigned LW = 14,
  parameter int unsigned AW = 13
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          restart_i,
  input  logic [LW-1:0]                 n_i,
  output pord_pkg::pord_stat_t          stat_o,
  input  logic                          queue_empty_i,
  input  pord_pkg::pord_job_t           job_i,
  output logic                          pop_o,
  output logic [AW-1:0]                 raddr_o,
  input  logic                          seen_rdata_i,
  input  logic [AW-1:0]                 img_rdata_i,
  output logic                          seen_we_o,
  output logic [AW-1:0]                 seen_waddr_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [pord_pkg::STATUS_W-1:0] status_o,
  output logic [pord_pkg::ORDER_W-1:0]  order_o,
  output logic                          is_identity_o
);
  import pord_pkg::*;

  typedef enum logic [3:0] {
    B_CLEAR, B_IDLE, B_RD, B_CHK, B_FOL, B_FOLW, B_NEXT,
    B_GCD, B_GWAIT, B_QWAIT, B_MUL0, B_MUL1, B_SUM, B_OUT
  } bstate_e;

  localparam int unsigned PW = HALF_W + LW;
  localparam int unsigned TW = ORDER_W + LW;

  bstate_e             state_q;
  logic [LW-1:0]       clr_q;
  logic [LW-1:0]       m_q;
  logic [AW-1:0]       j_q;
  logic [LW-1:0]       len_q;
  logic [ORDER_W-1:0]  acc_q;
  logic [ORDER_W-1:0]  a_q;
  logic [LW-1:0]       b_q;
  logic [LW-1:0]       k_q;
  logic [PW-1:0]       plo_q;
  logic [PW-1:0]       phi_q;
  logic                sat_q;
  logic                ident_q;
  logic                bad_q;
  logic                out_valid_q;
  logic [STATUS_W-1:0] status_q;
  logic [ORDER_W-1:0]  order_q;
  logic                ident_out_q;

  logic                div_start;
  logic [ORDER_W-1:0]  div_a;
  logic [LW-1:0]       div_b;
  logic                div_done;
  logic [ORDER_W-1:0]  div_quo;
  logic [LW-1:0]       div_rem;
  logic [TW-1:0]       total;

  pord_div #(.DW(ORDER_W), .VW(LW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .a_i     (div_a),
    .b_i     (div_b),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  assign total = {phi_q, {HALF_W{1'b0}}} + TW'(plo_q);

  always_comb begin
    div_start = 1'b0;
    div_a     = a_q;
    div_b     = b_q;
    if (state_q == B_GCD) begin
      div_start = 1'b1;
      if (b_q == '0) begin
        div_a = ORDER_W'(len_q);
        div_b = a_q[LW-1:0];
      end
    end
  end

  assign stat_o.idle        = (state_q == B_IDLE);
  assign stat_o.queue_empty = queue_empty_i;
  assign pop_o   = (state_q == B_IDLE) && !queue_empty_i && !restart_i;
  assign raddr_o = (state_q == B_FOL) ? j_q : AW'(m_q);

  always_comb begin
    seen_we_o    = 1'b0;
    seen_waddr_o = AW'(clr_q);
    unique case (state_q)
      B_CLEAR: seen_we_o = 1'b1;
      B_CHK: begin
        seen_we_o    = seen_rdata_i;
        seen_waddr_o = AW'(m_q);
      end
      B_FOL: begin
        seen_we_o    = (j_q != AW'(m_q));
        seen_waddr_o = j_q;
      end
      default: seen_we_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      m_q         <= '0;
      len_q       <= '0;
      sat_q       <= 1'b0;
      ident_q     <= 1'b1;
      bad_q       <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        B_CLEAR: begin
          clr_q <= clr_q + LW'(1);
          if (clr_q == LW'(MAX_POINTS - 1)) begin
            state_q <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (restart_i) begin
            clr_q   <= '0;
            state_q <= B_CLEAR;
          end else if (!queue_empty_i) begin
            m_q     <= '0;
            acc_q   <= ORDER_W'(1);
            sat_q   <= 1'b0;
            ident_q <= 1'b1;
            bad_q   <= job_i.invalid;
            state_q <= job_i.invalid ? B_OUT : B_RD;
          end
        end
        B_RD: state_q <= B_CHK;
        B_CHK: begin
          if (seen_rdata_i) begin
            j_q     <= img_rdata_i;
            len_q   <= LW'(1);
            state_q <= B_FOL;
          end else begin
            state_q <= B_NEXT;
          end
        end
        B_FOL: begin
          if (j_q == AW'(m_q)) begin
            if (len_q != LW'(1)) begin
              ident_q <= 1'b0;
            end
            if (len_q != LW'(1) && !sat_q) begin
              a_q     <= acc_q;
              b_q     <= len_q;
              state_q <= B_GCD;
            end else begin
              state_q <= B_NEXT;
            end
          end else begin
            len_q   <= len_q + LW'(1);
            state_q <= B_FOLW;
          end
        end
        B_FOLW: begin
          j_q     <= img_rdata_i;
          state_q <= B_FOL;
        end
        B_NEXT: begin
          if (m_q + LW'(1) == n_i) begin
            state_q <= B_OUT;
          end else begin
            m_q     <= m_q + LW'(1);
            state_q <= B_RD;
          end
        end
        B_GCD: state_q <= (b_q == '0) ? B_QWAIT : B_GWAIT;
        B_GWAIT: begin
          if (div_done) begin
            a_q     <= ORDER_W'(b_q);
            b_q     <= div_rem;
            state_q <= B_GCD;
          end
        end
        B_QWAIT: begin
          if (div_done) begin
            k_q     <= div_quo[LW-1:0];
            state_q <= B_MUL0;
          end
        end
        B_MUL0: begin
          plo_q   <= PW'(acc_q[HALF_W-1:0]) * PW'(k_q);
          state_q <= B_MUL1;
        end
        B_MUL1: begin
          phi_q   <= PW'(acc_q[ORDER_W-1:HALF_W]) * PW'(k_q);
          state_q <= B_SUM;
        end
        B_SUM: begin
          if (|total[TW-1:ORDER_W]) begin
            sat_q <= 1'b1;
          end else begin
            acc_q <= total[ORDER_W-1:0];
          end
          state_q <= B_NEXT;
        end
        B_OUT: begin
          if (!out_valid_q) begin
            out_valid_q <= 1'b1;
            if (bad_q) begin
              status_q    <= STATUS_BAD;
              order_q     <= '0;
              ident_out_q <= 1'b0;
              clr_q       <= '0;
              state_q     <= B_CLEAR;
            end else begin
              if (sat_q) begin
                status_q    <= STATUS_SAT;
                order_q     <= ORDER_MAX;
                ident_out_q <= 1'b0;
              end else begin
                status_q    <= STATUS_OK;
                order_q     <= acc_q;
                ident_out_q <= ident_q;
              end
              state_q <= B_IDLE;
            end
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign order_o       = order_q;
  assign is_identity_o = ident_out_q;

endmodule

// ===== rtl/permutation_order_top.sv =====
// top level of the permutation order block
//
//  channel   | handshake                      | payload
//  image in  | in_valid_i / in_ready_o        | image_i
//  result    | out_valid_o / out_ready_i      | status_o, order_o, is_identity_o
//  config    | point_count_we_i (no wait)     | point_count_i
//
// each image is loaded as a mark memory read, then a check and write
// after the last image the walker visits each point and, per
// cycle longer than one, runs divider passes for gcd and quotient
// after reset, an invalid permutation and a config write while the walker
// is idle, the mark memory is swept over all MAX_POINTS entries, no image taken
// a held result does not stall loading of the next permutation
`timescale 1ns / 1ps
module permutation_order_top #(
  parameter int unsigned MAX_POINTS = 8192
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          point_count_we_i,
  input  logic [pord_pkg::COUNT_W-1:0]  point_count_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [pord_pkg::IMAGE_W-1:0]  image_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [pord_pkg::STATUS_W-1:0] status_o,
  output logic [pord_pkg::ORDER_W-1:0]  order_o,
  output logic                          is_identity_o
);
  import pord_pkg::*;

  localparam int unsigned LW = $clog2(MAX_POINTS + 1);
  localparam int unsigned AW = $clog2(MAX_POINTS);

  logic [COUNT_W-1:0] pc_q;
  logic [LW-1:0]      n_eff;

  pord_stat_t    stat;
  pord_job_t     push_data;
  pord_job_t     pop_data;
  logic          push;
  logic          pop;
  logic          q_empty;
  logic          q_full;

  logic [AW-1:0] f_seen_raddr;
  logic          f_seen_we;
  logic [AW-1:0] f_seen_waddr;
  logic          f_img_we;
  logic [AW-1:0] f_img_waddr;
  logic [AW-1:0] f_img_wdata;
  logic [AW-1:0] b_raddr;
  logic          b_seen_we;
  logic [AW-1:0] b_seen_waddr;

  logic          own;
  logic          seen_we;
  logic [AW-1:0] seen_waddr;
  logic [AW-1:0] seen_raddr;
  logic          seen_rdata;
  logic [AW-1:0] img_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= COUNT_W'(8192);
    end else if (point_count_we_i) begin
      pc_q <= point_count_i;
    end
  end

  always_comb begin
    if (pc_q == '0) begin
      n_eff = LW'(1);
    end else if (32'(pc_q) > 32'(MAX_POINTS)) begin
      n_eff = LW'(MAX_POINTS);
    end else begin
      n_eff = LW'(pc_q);
    end
  end

  assign own        = !stat.idle;
  assign seen_we    = own ? b_seen_we : f_seen_we;
  assign seen_waddr = own ? b_seen_waddr : f_seen_waddr;
  assign seen_raddr = own ? b_raddr : f_seen_raddr;

  pord_ram #(.WIDTH(1), .DEPTH(MAX_POINTS)) u_seen (
    .clk_i   (clk_i),
    .we_i    (seen_we),
    .waddr_i (seen_waddr),
    .wdata_i (!own),
    .raddr_i (seen_raddr),
    .rdata_o (seen_rdata)
  );

  pord_ram #(.WIDTH(AW), .DEPTH(MAX_POINTS)) u_img (
    .clk_i   (clk_i),
    .we_i    (f_img_we),
    .waddr_i (f_img_waddr),
    .wdata_i (f_img_wdata),
    .raddr_i (b_raddr),
    .rdata_o (img_rdata)
  );

  pord_front #(.LW(LW), .AW(AW)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .restart_i    (point_count_we_i),
    .n_i          (n_eff),
    .stat_i       (stat),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .image_i      (image_i),
    .seen_raddr_o (f_seen_raddr),
    .seen_rdata_i (seen_rdata),
    .seen_we_o    (f_seen_we),
    .seen_waddr_o (f_seen_waddr),
    .img_we_o     (f_img_we),
    .img_waddr_o  (f_img_waddr),
    .img_wdata_o  (f_img_wdata),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  pord_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  pord_back #(.MAX_POINTS(MAX_POINTS), .LW(LW), .AW(AW)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .restart_i     (point_count_we_i),
    .n_i           (n_eff),
    .stat_o        (stat),
    .queue_empty_i (q_empty || q_full && 1'b0),
    .job_i         (pop_data),
    .pop_o         (pop),
    .raddr_o       (b_raddr),
    .seen_rdata_i  (seen_rdata),
    .img_rdata_i   (img_rdata),
    .seen_we_o     (b_seen_we),
    .seen_waddr_o  (b_seen_waddr),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .order_o       (order_o),
    .is_identity_o (is_identity_o)
  );

endmodule

// ===== dv/tb.sv =====
// testbench for permutation_order_top: directed table, then random permutations vs a predictor
`timescale 1ns / 1ps
module tb;
  import pord_pkg::*;

  localparam int unsigned NPTS = 8192;
  localparam int unsigned SETTLE = 2 * NPTS + 400;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ORDER_W-1:0]  order;
    logic                ident;
  } order_res_t;

  typedef struct {
    logic        cfg;
    logic [13:0] value;
    logic        typed;
    order_res_t  res;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                pc_we = 1'b0;
  logic [COUNT_W-1:0]  pc_val = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [IMAGE_W-1:0]  image = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [ORDER_W-1:0]  order;
  logic                is_ident;

  permutation_order_top dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .point_count_we_i (pc_we),
    .point_count_i    (pc_val),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .image_i          (image),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .status_o         (status),
    .order_o          (order),
    .is_identity_o    (is_ident)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  int unsigned img_mem [NPTS];
  bit          seen    [NPTS];
  int unsigned loaded;
  bit          bad_perm;
  int unsigned count_reg;
  order_res_t  order_q[$];

  int errors = 0;
  bit calm = 1'b0;
  int hold_cycles = 0;
  int unsigned perm [NPTS];

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic int unsigned eff_count();
    if (count_reg == 0) return 1;
    if (count_reg > NPTS) return NPTS;
    return count_reg;
  endfunction

  function automatic void clear_perm();
    foreach (seen[i]) seen[i] = 1'b0;
    loaded = 0;
    bad_perm = 1'b0;
  endfunction

  function automatic logic [63:0] gcd64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    while (b != 0) begin
      r = a % b;
      a = b;
      b = r;
    end
    return a;
  endfunction

  // returns 1 on a new expected result
  function automatic bit predict_order(input int unsigned img, output order_res_t res);
    int unsigned n;
    int unsigned j;
    logic [63:0] acc;
    logic [63:0] len;
    logic [63:0] part;
    bit sat;
    bit ident;
    n = eff_count();
    if (loaded >= n) clear_perm();
    if (img == 0 || img > n || seen[img-1]) begin
      bad_perm = 1'b1;
      img_mem[loaded] = 0;
    end else begin
      seen[img-1] = 1'b1;
      img_mem[loaded] = img - 1;
    end
    loaded++;
    if (loaded < n) return 1'b0;
    if (bad_perm) begin
      res = '{STATUS_BAD, '0, 1'b0};
      clear_perm();
      return 1'b1;
    end
    acc = 1;
    sat = 1'b0;
    ident = 1'b1;
    for (int unsigned m = 0; m < n; m++) begin
      if (!seen[m]) continue;
      seen[m] = 1'b0;
      len = 1;
      j = img_mem[m];
      while (j != m && j < n) begin
        seen[j] = 1'b0;
        len++;
        j = img_mem[j];
      end
      if (len > 1) begin
        ident = 1'b0;
        if (!sat) begin
          part = acc / gcd64(acc, len);
          if (part > {16'd0, ORDER_MAX} / len) sat = 1'b1;
          else acc = part * len;
        end
      end
    end
    if (sat) res = '{STATUS_SAT, ORDER_MAX, 1'b0};
    else res = '{STATUS_OK, acc[ORDER_W-1:0], ident};
    clear_perm();
    return 1'b1;
  endfunction

  task automatic write_count(input logic [13:0] v);
    wait (order_q.size() == 0);
    repeat (SETTLE) @(posedge clk);
    pc_we <= 1'b1;
    pc_val <= v;
    @(posedge clk);
    pc_we <= 1'b0;
    count_reg = v;
    clear_perm();
  endtask

  // called at a clock edge; returns at the edge of the transfer
  task automatic send_image(input logic [13:0] v, input bit typed, input order_res_t typed_res);
    order_res_t res;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    image <= v;
    do @(posedge clk); while (!in_ready);
    if (predict_order(v, res)) order_q.push_back(typed ? typed_res : res);
  endtask

  task automatic send_perm(input int unsigned n);
    order_res_t nores;
    nores = '0;
    for (int unsigned i = 0; i < n; i++) send_image(perm[i][13:0], 1'b0, nores);
  endtask

  // mode 0 shuffle, 1 identity, 2 prime cycles
  function automatic void build_perm(input int unsigned n, input int mode);
    int unsigned primes [14] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43};
    int unsigned k;
    int unsigned t;
    int unsigned base;
    for (int unsigned i = 0; i < n; i++) perm[i] = i + 1;
    if (mode == 0) begin
      for (int unsigned i = n - 1; i > 0; i--) begin
        k = $urandom_range(0, i);
        t = perm[i];
        perm[i] = perm[k];
        perm[k] = t;
      end
    end else if (mode == 2) begin
      base = 0;
      foreach (primes[p]) begin
        if (base + primes[p] <= n) begin
          for (int unsigned i = 0; i < primes[p]; i++)
            perm[base+i] = base + ((i + 1) % primes[p]) + 1;
          base += primes[p];
        end
      end
    end
    if ($urandom_range(0, 4) == 0) begin
      k = $urandom_range(0, n - 1);
      if ($urandom_range(0, 1) == 0) perm[k] = $urandom_range(0, 16383);
      else perm[k] = perm[$urandom_range(0, n - 1)];
    end
  endfunction

  initial begin
    out_ready <= 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9) - 1) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    order_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (order_q.size() == 0) begin
        report("unexpected result", {62'd0, status}, 64'd0);
      end else begin
        want = order_q.pop_front();
        if (status !== want.status) report("status", {62'd0, status}, {62'd0, want.status});
        if (order !== want.order) report("order", {16'd0, order}, {16'd0, want.order});
        if (is_ident !== want.ident) report("is_identity", {63'd0, is_ident}, {63'd0, want.ident});
      end
    end
  end

  initial begin
    #100_000_000;
    $display("permutation_order_top test failed");
    $finish;
  end

  dir_row_t rows [$];
  int unsigned cnt;
  int unsigned sent;

  initial begin
    rows = '{
      '{1'b1, 14'd0,     1'b0, '0},
      '{1'b0, 14'd1,     1'b1, '{STATUS_OK, 48'd1, 1'b1}},
      '{1'b0, 14'd0,     1'b1, '{STATUS_BAD, 48'd0, 1'b0}},
      '{1'b0, 14'd2,     1'b1, '{STATUS_BAD, 48'd0, 1'b0}},
      '{1'b0, 14'd16383, 1'b1, '{STATUS_BAD, 48'd0, 1'b0}},
      '{1'b1, 14'd2,     1'b0, '0},
      '{1'b0, 14'd2,     1'b0, '0},
      '{1'b0, 14'd1,     1'b1, '{STATUS_OK, 48'd2, 1'b0}},
      '{1'b0, 14'd1,     1'b0, '0},
      '{1'b0, 14'd1,     1'b1, '{STATUS_BAD, 48'd0, 1'b0}},
      '{1'b1, 14'd3,     1'b0, '0},
      '{1'b0, 14'd1,     1'b0, '0},
      '{1'b0, 14'd3,     1'b0, '0},
      '{1'b1, 14'd3,     1'b0, '0},
      '{1'b0, 14'd2,     1'b0, '0},
      '{1'b0, 14'd3,     1'b0, '0},
      '{1'b0, 14'd1,     1'b1, '{STATUS_OK, 48'd3, 1'b0}},
      '{1'b1, 14'd5,     1'b0, '0},
      '{1'b0, 14'd2,     1'b0, '0},
      '{1'b0, 14'd1,     1'b0, '0},
      '{1'b0, 14'd4,     1'b0, '0},
      '{1'b0, 14'd5,     1'b0, '0},
      '{1'b0, 14'd3,     1'b1, '{STATUS_OK, 48'd6, 1'b0}}
    };
    count_reg = NPTS;
    clear_perm();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[r]) begin
      if (rows[r].cfg) begin
        in_valid <= 1'b0;
        write_count(rows[r].value);
      end else begin
        send_image(rows[r].value, rows[r].typed, rows[r].res);
      end
    end
    for (int p = 0; p < 12; p++) begin
      in_valid <= 1'b0;
      case (p)
        0: cnt = 16383;
        1: cnt = 300;
        2: cnt = 1;
        3, 4, 7: cnt = $urandom_range(13, 64);
        default: cnt = $urandom_range(2, 12);
      endcase
      calm = (p == 11);
      write_count(cnt[13:0]);
      cnt = eff_count();
      sent = 0;
      if (p == 6) hold_cycles = 3000;
      do begin
        if (p == 1) build_perm(cnt, 2);
        else build_perm(cnt, ($urandom_range(0, 7) == 0) ? 1 : 0);
        // p == 0 sends a partial load with the clamped count, dropped by the next count write
        send_perm((p == 0) ? 100 : cnt);
        sent += cnt;
        if (p == 8 && sent > 40 && sent <= 40 + cnt) begin
          in_valid <= 1'b0;
          wait (order_q.size() == 0);
          @(posedge clk);
        end
      end while (sent < 90 && p > 1);
    end
    in_valid <= 1'b0;
    wait (order_q.size() == 0);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("permutation_order_top test passed");
    end else begin
      $display("permutation_order_top test failed");
    end
    $finish;
  end

endmodule
